>>> sv/rlm_pkg.sv
// Shared types and constants for the RMS level meter.
package rlm_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int COUNT_BITS  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int SUM_BITS  = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int NUM_BITS  = SUM_BITS + 16;
  localparam int MSQ_BITS  = 2 * SAMPLE_BITS + 16;
  localparam int ROOT_W    = MSQ_BITS / 2;
  localparam int TOP_W     = $clog2(MSQ_BITS);
  localparam int LOG_BIAS  = 2 * (SAMPLE_BITS - 1) + 16;
  localparam int DB_K      = 197283;
  localparam int DB_FLOOR  = -32768;
  localparam int DB_CEIL   = 32767;
  localparam int RMS_MAX   = 262143;

  localparam logic [SAMPLE_BITS-1:0] OFFSET_RESET = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        sample_count;
    logic [17:0]        rms_value;
    logic signed [15:0] level_db;
    logic               window_empty;
    logic               count_overflow;
  } out_item_t;

  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] mag;
  } q_entry_t;

endpackage

>>> sv/rms_level_meter_db_unit.sv
// Top level of the RMS level meter with dB readout.
// Accumulate transfers: one per cycle sustained through the two-entry queue and back end
// while no readout is busy. Readout: divide, root, normalise, log, multiply, scale, output;
// a zero signal skips from root to output, and an empty window goes straight to output.
// Input stalls once the queue is full behind a readout or a held result.
// Reset: offset returns to midscale, sum, count and overflow clear at once, no result held.
module rms_level_meter_db_unit import rlm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              out_data_o
);

  logic     q_full, q_push, q_pop, q_empty;
  q_entry_t q_wdata, q_rdata;

  rlm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  rlm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  rlm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sv/rlm_front.sv
// Front end: offset register, input acceptance and sample magnitude.
module rlm_front import rlm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output q_entry_t               q_data_o
);

  logic [SAMPLE_BITS-1:0] offset_q, offset_d;
  logic [SAMPLE_BITS-1:0] smp;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign q_push_o    = in_valid_i && !q_full_i;

  always_comb begin
    offset_d = offset_q;
    if (cfg_valid_i) begin
      offset_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
    end else begin
      offset_q <= offset_d;
    end
  end

  assign smp = SAMPLE_BITS'(in_data_i.sample);

  always_comb begin
    q_data_o.op  = in_data_i.op;
    q_data_o.mag = (smp >= offset_q) ? (smp - offset_q) : (offset_q - smp);
  end

endmodule

>>> sv/rlm_queue.sv
// Short queue between the front end and the back end.
module rlm_queue import rlm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output q_entry_t pop_data_o
);

  q_entry_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]     cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/rlm_back.sv
// Back end: accumulator, readout sequencer (divide, root, normalise, log, multiply, scale) and result register.
module rlm_back import rlm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  q_entry_t  q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int CNT_W = $clog2(NUM_BITS + 1);
  localparam int SR_W  = ROOT_W + 3;
  localparam int X_W   = TOP_W + 17;
  localparam int P_W   = X_W + 19;
  localparam int LV_W  = P_W - 24;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SQRT  = 3'd2;
  localparam logic [2:0] S_NORM  = 3'd3;
  localparam logic [2:0] S_LOG   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_SCALE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic signed [X_W-1:0]  X_BIAS = X_W'(LOG_BIAS * 65536);
  localparam logic signed [P_W-1:0]  K_EXT  = P_W'(DB_K);
  localparam logic signed [P_W-1:0]  RND    = P_W'(1 << 23);
  localparam logic signed [LV_W-1:0] LV_MIN = LV_W'(DB_FLOOR);
  localparam logic signed [LV_W-1:0] LV_MAX = LV_W'(DB_CEIL);

  logic [2:0]            state_q, state_d;
  logic [SUM_BITS-1:0]   sum_q, sum_d;
  logic [COUNT_BITS-1:0] tally_q, tally_d;
  logic                  ovf_q, ovf_d;

  logic [NUM_BITS-1:0]   num_q, num_d;
  logic [COUNT_BITS-1:0] div_q, div_d;
  logic [COUNT_BITS:0]   rem_q, rem_d;
  logic [MSQ_BITS-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [MSQ_BITS-1:0]   rad_q, rad_d;
  logic [SR_W-1:0]       srem_q, srem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [MSQ_BITS-1:0]   norm_q, norm_d;
  logic [TOP_W-1:0]      top_q, top_d;
  logic [30:0]           m_q, m_d;
  logic [15:0]           frac_q, frac_d;
  logic signed [P_W-1:0] prod_q, prod_d;
  logic signed [15:0]    level_q, level_d;
  logic [15:0]           rcount_q, rcount_d;
  logic                  rempty_q, rempty_d;
  logic                  rovf_q, rovf_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  logic [2*SAMPLE_BITS-1:0] mag_sq;
  logic [COUNT_BITS:0]   r2;
  logic                  dge;
  logic [SR_W-1:0]       sr2, trial;
  logic                  sge;
  logic [61:0]           sq;
  logic [31:0]           m2;
  logic signed [X_W-1:0] x;
  logic signed [P_W-1:0] x_ext, biased;
  logic signed [LV_W-1:0] lv;

  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    mag_sq = (2*SAMPLE_BITS)'(q_data_i.mag) * (2*SAMPLE_BITS)'(q_data_i.mag);
    r2     = {rem_q[COUNT_BITS-1:0], num_q[NUM_BITS-1]};
    dge    = (r2 >= {1'b0, div_q});
    sr2    = {srem_q[SR_W-3:0], rad_q[MSQ_BITS-1 -: 2]};
    trial  = SR_W'({root_q, 2'b01});
    sge    = (sr2 >= trial);
    sq     = 62'(m_q) * 62'(m_q);
    m2     = sq[61:30];
    x      = $signed({1'b0, top_q, frac_q}) - X_BIAS;
    x_ext  = P_W'(x);
    biased = prod_q + RND;
    lv     = LV_W'(biased >>> 24);
  end

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    tally_d     = tally_q;
    ovf_d       = ovf_q;
    num_d       = num_q;
    div_d       = div_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    rad_d       = rad_q;
    srem_d      = srem_q;
    root_d      = root_q;
    norm_d      = norm_q;
    top_d       = top_q;
    m_d         = m_q;
    frac_d      = frac_q;
    prod_d      = prod_q;
    level_d     = level_q;
    rcount_d    = rcount_q;
    rempty_d    = rempty_q;
    rovf_d      = rovf_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          if (q_data_i.op == OP_ACCUM) begin
            if (tally_q == {COUNT_BITS{1'b1}}) begin
              ovf_d = 1'b1;
            end else begin
              tally_d = tally_q + 1'b1;
              sum_d   = sum_q + SUM_BITS'(mag_sq);
            end
          end else begin
            num_d    = {sum_q, 16'b0};
            div_d    = tally_q;
            rem_d    = '0;
            quo_d    = '0;
            cnt_d    = '0;
            root_d   = '0;
            level_d  = 16'(DB_FLOOR);
            rcount_d = 16'(tally_q);
            rempty_d = (tally_q == '0);
            rovf_d   = ovf_q;
            sum_d    = '0;
            tally_d  = '0;
            ovf_d    = 1'b0;
            state_d  = (tally_q == '0) ? S_DONE : S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_d = dge ? (r2 - {1'b0, div_q}) : r2;
        quo_d = {quo_q[MSQ_BITS-2:0], dge};
        num_d = num_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_BITS - 1)) begin
          rad_d   = {quo_q[MSQ_BITS-2:0], dge};
          srem_d  = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        srem_d = sge ? (sr2 - trial) : sr2;
        root_d = {root_q[ROOT_W-2:0], sge};
        rad_d  = rad_q << 2;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          norm_d  = quo_q;
          top_d   = TOP_W'(MSQ_BITS - 1);
          state_d = (quo_q == '0) ? S_DONE : S_NORM;
        end
      end
      S_NORM: begin
        if (norm_q[MSQ_BITS-1]) begin
          m_d     = norm_q[MSQ_BITS-1 -: 31];
          frac_d  = '0;
          cnt_d   = '0;
          state_d = S_LOG;
        end else begin
          norm_d = norm_q << 1;
          top_d  = top_q - 1'b1;
        end
      end
      S_LOG: begin
        m_d    = m2[31] ? m2[31:1] : m2[30:0];
        frac_d = {frac_q[14:0], m2[31]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(15)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = x_ext * K_EXT;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        if (lv < LV_MIN) begin
          level_d = 16'(DB_FLOOR);
        end else if (lv > LV_MAX) begin
          level_d = 16'(DB_CEIL);
        end else begin
          level_d = 16'(lv);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.sample_count   = rcount_q;
          out_d.rms_value      = (root_q > ROOT_W'(RMS_MAX)) ? 18'(RMS_MAX) : 18'(root_q);
          out_d.level_db       = level_q;
          out_d.window_empty   = rempty_q;
          out_d.count_overflow = rovf_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      tally_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      tally_q     <= tally_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    rad_q    <= rad_d;
    srem_q   <= srem_d;
    root_q   <= root_d;
    norm_q   <= norm_d;
    top_q    <= top_d;
    m_q      <= m_d;
    frac_q   <= frac_d;
    prod_q   <= prod_d;
    level_q  <= level_d;
    rcount_q <= rcount_d;
    rempty_q <= rempty_d;
    rovf_q   <= rovf_d;
    out_q    <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_clear_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_data_i.op == OP_READ) |=> (sum_q == '0 && tally_q == '0 && !ovf_q))
    else $error("accumulator not cleared after readout");
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < {1'b0, div_q}))
    else $error("divider remainder out of range");
  a_norm_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NORM && norm_q[MSQ_BITS-1]) |=> (state_q == S_LOG))
    else $error("normaliser did not hand over");
  a_log_mant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOG) |-> m_q[30])
    else $error("log mantissa not normalised");
`endif

endmodule
